// ----- sv/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants of the binomial coefficient unit
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int MaxSites = 64;
  localparam int SiteW    = 7;
  localparam int ValW     = 64;
  localparam int CntW     = 7;

  localparam logic [SiteW-1:0] MaxSitesV = SiteW'(MaxSites);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,        // latch inputs, product = 1, step = 1
    CMD_SET_TOTAL,   // product = total
    CMD_GCD_START,   // a = product, b = step
    CMD_MOD_START,   // start divider on a / b
    CMD_DIV_STEP,    // four divider bits
    CMD_GCD_NEXT,    // a = b, b = remainder
    CMD_PDIV_START,  // start divider on product / g
    CMD_PROD_SET,    // product = quotient, start divider on step / g
    CMD_FDIV_START,  // start divider on remaining / div
    CMD_MUL          // product *= factor, advance step
  } cmd_t;

  typedef struct packed {
    logic       range_err;
    logic       total_zero;
    logic       trivial_one;
    logic       choose_one;
    logic       div_done;
    logic       b_zero;
    logic       mul_ovf;
    logic       last_step;
  } dp_status_t;

endpackage

// ----- sv/bcc_datapath.sv -----
// ----------------------------------------------------------------------------
// bcc_datapath
// shared radix-16 divider by a small divisor, checked multiply, working regs
// ----------------------------------------------------------------------------
module bcc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bcc_pkg::cmd_t         cmd,
  input  logic [6:0]            total_in,
  input  logic [6:0]            chosen_in,
  output bcc_pkg::dp_status_t   stat,
  output logic [63:0]           product
);
  import bcc_pkg::*;

  logic [SiteW-1:0] total_r, chosen, remaining_total;
  logic [CntW-1:0]  step_index;
  logic [ValW-1:0]  euclid_a, euclid_b;
  // divider: every divisor and remainder here is at most 64
  logic [ValW-1:0]  num, quo, num_next, quo_next, go_num;
  logic [SiteW-1:0] den, rem, rem_next, go_den;
  logic [SiteW:0]   trial;
  logic [4:0]       dcnt;
  logic             div_go;
  logic [ValW+SiteW-1:0] mul_full;

  assign mul_full = {{SiteW{1'b0}}, product} * {{ValW{1'b0}}, quo[SiteW-1:0]};

  assign stat.range_err   = (total_r > MaxSitesV) || (chosen > MaxSitesV) ||
                            (chosen > total_r);
  assign stat.total_zero  = (total_r == '0);
  assign stat.trivial_one = (chosen == '0) || (chosen == total_r);
  assign stat.choose_one  = (chosen == 7'd1);
  assign stat.div_done    = (dcnt == 5'd0);
  assign stat.b_zero      = (euclid_b == '0);
  assign stat.mul_ovf     = (mul_full[ValW+SiteW-1:ValW] != '0);
  assign stat.last_step   = (step_index == chosen);

  // four restoring steps per cycle
  always_comb begin
    num_next = num;
    quo_next = quo;
    rem_next = rem;
    trial = '0;
    for (int b = 0; b < 4; b++) begin
      trial = {rem_next, num_next[ValW-1]};
      num_next = {num_next[ValW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = SiteW'(trial - {1'b0, den});
        quo_next = {quo_next[ValW-2:0], 1'b1};
      end else begin
        rem_next = trial[SiteW-1:0];
        quo_next = {quo_next[ValW-2:0], 1'b0};
      end
    end
  end

  // divider operand select
  always_comb begin
    div_go = 1'b1;
    go_num = '0;
    go_den = '0;
    case (cmd)
      CMD_MOD_START: begin
        go_num = euclid_a; go_den = euclid_b[SiteW-1:0];
      end
      CMD_PDIV_START: begin
        go_num = product; go_den = euclid_a[SiteW-1:0];
      end
      CMD_PROD_SET: begin
        go_num = {{(ValW-CntW){1'b0}}, step_index}; go_den = euclid_a[SiteW-1:0];
      end
      CMD_FDIV_START: begin
        go_num = {{(ValW-SiteW){1'b0}}, remaining_total};
        go_den = (quo[SiteW-1:0] == '0) ? SiteW'(1) : quo[SiteW-1:0];
      end
      default: div_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product <= '0; remaining_total <= '0; step_index <= '0;
      total_r <= '0; chosen <= '0;
      euclid_a <= '0; euclid_b <= '0;
      num <= '0; quo <= '0; den <= '0; rem <= '0; dcnt <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          total_r <= total_in; chosen <= chosen_in;
          product <= 64'd1; remaining_total <= total_in; step_index <= 7'd1;
        end
        CMD_SET_TOTAL: product <= {{(ValW-SiteW){1'b0}}, total_r};
        CMD_GCD_START: begin
          euclid_a <= product; euclid_b <= {{(ValW-CntW){1'b0}}, step_index};
        end
        CMD_GCD_NEXT: begin
          euclid_a <= euclid_b; euclid_b <= {{(ValW-SiteW){1'b0}}, rem};
        end
        CMD_PROD_SET: product <= quo;
        CMD_DIV_STEP: begin
          num <= num_next; quo <= quo_next; rem <= rem_next;
          dcnt <= dcnt - 5'd1;
        end
        CMD_MUL: begin
          product <= mul_full[ValW-1:0];
          remaining_total <= remaining_total - 7'd1;
          step_index <= step_index + 7'd1;
        end
        default: ;
      endcase
      if (div_go) begin
        den <= go_den; quo <= '0; rem <= '0;
        // a numerator below 256 needs only two passes
        if (go_num[ValW-1:8] == '0) begin
          num <= {go_num[7:0], 56'd0}; dcnt <= 5'd2;
        end else begin
          num <= go_num; dcnt <= 5'd16;
        end
      end
    end
  end
endmodule

// ----- sv/bcc_controller.sv -----
// ----------------------------------------------------------------------------
// bcc_controller
// sequencer over special cases, gcd loop, divisions and checked multiply
// ----------------------------------------------------------------------------
module bcc_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_comb,
  output logic [1:0]          m_status,
  output bcc_pkg::cmd_t       cmd,
  input  bcc_pkg::dp_status_t stat,
  input  logic [63:0]         product
);
  import bcc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLASS = 4'd1, S_GCD = 4'd2, S_GTEST = 4'd3,
    S_GMOD = 4'd4, S_PDIV = 4'd5, S_SDIV = 4'd6, S_FDIV = 4'd7, S_MUL = 4'd8,
    S_OUT = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] res_status, res_status_next;
  logic       out_load, m_tvalid_next;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    cmd = CMD_NOP;
    state_next = state;
    res_status_next = res_status;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: if (s_tvalid) begin cmd = CMD_LOAD; state_next = S_CLASS; end
      S_CLASS: begin
        res_status_next = STATUS_OK;
        if (stat.range_err) begin
          res_status_next = STATUS_RANGE; state_next = S_OUT;
        end else if (stat.total_zero) begin
          cmd = CMD_SET_TOTAL; state_next = S_OUT;
        end else if (stat.trivial_one) begin
          state_next = S_OUT;
        end else if (stat.choose_one) begin
          cmd = CMD_SET_TOTAL; state_next = S_OUT;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin cmd = CMD_GCD_START; state_next = S_GTEST; end
      S_GTEST: begin
        if (stat.b_zero) begin cmd = CMD_PDIV_START; state_next = S_PDIV; end
        else begin cmd = CMD_MOD_START; state_next = S_GMOD; end
      end
      S_GMOD: begin
        if (stat.div_done) begin cmd = CMD_GCD_NEXT; state_next = S_GTEST; end
        else cmd = CMD_DIV_STEP;
      end
      S_PDIV: begin
        if (stat.div_done) begin cmd = CMD_PROD_SET; state_next = S_SDIV; end
        else cmd = CMD_DIV_STEP;
      end
      S_SDIV: begin
        if (stat.div_done) begin cmd = CMD_FDIV_START; state_next = S_FDIV; end
        else cmd = CMD_DIV_STEP;
      end
      S_FDIV: begin
        if (stat.div_done) state_next = S_MUL;
        else cmd = CMD_DIV_STEP;
      end
      S_MUL: begin
        if (stat.mul_ovf) begin
          res_status_next = STATUS_OVERFLOW; state_next = S_OUT;
        end else begin
          cmd = CMD_MUL;
          state_next = stat.last_step ? S_OUT : S_GCD;
        end
      end
      S_OUT: begin
        // waits here while the previous item is still held
        if (out_load) begin m_tvalid_next = 1'b1; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; res_status <= STATUS_OK; m_tvalid <= 1'b0;
      m_comb <= '0; m_status <= STATUS_OK;
    end else begin
      state <= state_next;
      res_status <= res_status_next;
      m_tvalid <= m_tvalid_next;
      if (out_load) begin
        m_comb <= (res_status == STATUS_OK) ? product : '0;
        m_status <= res_status;
      end
    end
  end
endmodule

// ----- sv/binomial_coefficient_calc.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_calc
// binomial coefficient c(total, chosen) with overflow and range status
// ----------------------------------------------------------------------------
// Takes one item (total_sites, chosen_sites) and returns one item holding the
// 64-bit coefficient and a status (0 ok, 1 overflow, 2 chosen above total or
// input above 64). One item is worked on at a time; input is taken only when
// the sequencer is idle, and a finished result waits in the output register so
// the next item can start while it is held. Range errors and the trivial cases
// (total zero, chosen zero, one or equal to total) go from the classify state
// straight to the output state. Otherwise each of the chosen loop steps runs
// a gcd by Euclid's method, three divisions and a checked multiply on a
// divider that retires four quotient bits a cycle (all 64 numerator bits
// for a wide numerator, the low 8 when it fits in 8 bits); the length of a
// step is set mostly by the number of Euclid rounds.
module binomial_coefficient_calc (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // total_sites[6:0], chosen_sites[13:7], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // combinations[63:0], status[65:64], zero
);
  import bcc_pkg::*;

  cmd_t        cmd;
  dp_status_t  stat;
  logic [63:0] product, comb;
  logic [1:0]  status;

  bcc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .total_in(s_tdata[6:0]),
    .chosen_in(s_tdata[13:7]), .stat(stat), .product(product)
  );

  bcc_controller u_ctl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_comb(comb), .m_status(status),
    .cmd(cmd), .stat(stat), .product(product)
  );

  assign m_tdata = {6'd0, status, comb};
endmodule
